// ===== rtl/core/wsd_pkg.sv =====
// Shared formats, constants and IMA-ADPCM arithmetic for the wave sample decoder.
package wsd_pkg;

  typedef enum logic [1:0] {
    FMT_PCM8   = 2'd0,
    FMT_PCM16  = 2'd1,
    FMT_ADPCM  = 2'd2,
    FMT_UNUSED = 2'd3
  } sample_format_t;

  localparam logic [6:0] STEP_MAX     = 7'd88;
  localparam logic [6:0] STEP_MASK    = 7'h7f;
  localparam logic [2:0] HEADER_BYTES = 3'd4;

  localparam logic [2:0] HDR_PRED_LO = 3'd0;
  localparam logic [2:0] HDR_PRED_HI = 3'd1;
  localparam logic [2:0] HDR_STEP    = 3'd2;

  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } adpcm_state_t;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] code);
    logic signed [4:0] a;
    case (code)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

  // One nibble update: predictor saturates at 16 bits, index clamps to 0..88.
  function automatic adpcm_state_t adpcm_nibble(input adpcm_state_t s, input logic [3:0] code);
    logic [6:0]         idx;
    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] sum;
    logic signed [4:0]  adj;
    logic signed [7:0]  nxt;
    adpcm_state_t       r;
    idx  = (s.idx > STEP_MAX) ? STEP_MAX : s.idx;
    step = step_size(idx);
    diff = {5'b0, step[14:3]};
    if (code[0]) diff = diff + {4'b0, step[14:2]};
    if (code[1]) diff = diff + {3'b0, step[14:1]};
    if (code[2]) diff = diff + {2'b0, step};
    if (code[3]) sum = {{2{s.pred[15]}}, s.pred} - $signed({1'b0, diff});
    else         sum = {{2{s.pred[15]}}, s.pred} + $signed({1'b0, diff});
    if (sum < -18'sd32768)     r.pred = 16'sh8000;
    else if (sum > 18'sd32767) r.pred = 16'sh7fff;
    else                       r.pred = sum[15:0];
    adj = index_adjust(code[2:0]);
    nxt = $signed({1'b0, idx}) + {{3{adj[4]}}, adj};
    if (nxt < 8'sd0)                       r.idx = 7'd0;
    else if (nxt > $signed({1'b0, STEP_MAX})) r.idx = STEP_MAX;
    else                                   r.idx = nxt[6:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/wsd_in_if.sv =====
// Byte input channel of the wave sample decoder.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       wave_start;

  modport source (output valid, output data_byte, output wave_start, input ready);
  modport sink   (input valid, input data_byte, input wave_start, output ready);
endinterface

// ===== rtl/core/wsd_out_if.sv =====
// Sample output channel of the wave sample decoder.
interface wsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_value;
  logic               last_of_item;

  modport source (output valid, output sample_value, output last_of_item, input ready);
  modport sink   (input valid, input sample_value, input last_of_item, output ready);
endinterface

// ===== rtl/core/wsd_cfg_if.sv =====
// Configuration write channel carrying the sample format register.
interface wsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] sample_format;

  modport source (output valid, output sample_format, input ready);
  modport sink   (input valid, input sample_format, output ready);
endinterface

// ===== rtl/core/wave_sample_decoder.sv =====
// Wave sample decoder: PCM8, PCM16 and IMA-ADPCM bytes to signed 16-bit samples.
// Path: a transferred byte is held in the input register, decoded into the result pair, then output.
// Throughput: one byte per cycle in PCM8/PCM16 while the output is not stalled; ADPCM data
// bytes give two samples each, so the one-sample-per-cycle output port limits their rate.
// Reset (rst, synchronous): clears decoder state, format to PCM8, input and output stages.
module wave_sample_decoder (
  input  logic          clk,
  input  logic          rst,
  wsd_in_if.sink        payload,
  wsd_out_if.source     samples,
  wsd_cfg_if.sink       cfg
);
  import wsd_pkg::*;

  // Configuration register; the user must write it only while the block is idle (not enforced here).
  sample_format_t sample_format;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_PCM8;
    end else if (cfg.valid && cfg.ready) begin
      sample_format <= sample_format_t'(cfg.sample_format);
    end
  end

  // Decoder state carried from byte to byte.
  logic signed [15:0] predictor;
  logic [6:0]         step_position;
  logic [2:0]         header_count;
  logic [7:0]         held_low_byte;
  logic               byte_phase;

  // Input register: holds one transferred byte until the result stage can take it.
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_start;

  // Result pair: up to two samples of one byte, head at entry 0.
  logic [1:0]         pair_count;
  logic signed [15:0] pair_sample [2];
  logic               pair_last   [2];

  logic in_fire;
  logic out_fire;
  logic process;

  assign in_fire  = payload.valid && payload.ready;
  assign out_fire = samples.valid && samples.ready;

  // Process the held byte when the pair is empty or empties at this edge.
  assign process = a_valid && ((pair_count == 2'd0) || ((pair_count == 2'd1) && out_fire));

  // Accept a new byte whenever the input register is free or drains now.
  assign payload.ready = !a_valid || process;

  assign samples.valid        = (pair_count != 2'd0);
  assign samples.sample_value = pair_sample[0];
  assign samples.last_of_item = pair_last[0];

  // Combinational decode of the held byte.
  logic signed [15:0] predictor_next;
  logic [6:0]         step_position_next;
  logic [2:0]         header_count_next;
  logic [7:0]         held_low_byte_next;
  logic               byte_phase_next;
  logic [1:0]         result_count;
  logic signed [15:0] result_sample [2];
  logic               result_last   [2];
  logic [2:0]         hc;
  logic               ph;
  adpcm_state_t       nib_lo;
  adpcm_state_t       nib_hi;
  logic [6:0]         hdr_idx;

  always_comb begin
    // A wave start restarts the header and any half-built PCM16 pair.
    hc = a_start ? 3'd0 : header_count;
    ph = a_start ? 1'b0 : byte_phase;

    // Two chained nibble updates: low nibble first, the high one from its result.
    nib_lo  = adpcm_nibble('{pred: predictor, idx: step_position}, a_byte[3:0]);
    nib_hi  = adpcm_nibble(nib_lo, a_byte[7:4]);
    hdr_idx = a_byte[6:0] & STEP_MASK;

    predictor_next     = predictor;
    step_position_next = step_position;
    header_count_next  = hc;
    held_low_byte_next = held_low_byte;
    byte_phase_next    = ph;
    result_count       = 2'd0;
    result_sample[0]   = {a_byte, 8'h00};
    result_sample[1]   = nib_hi.pred;
    result_last[0]     = 1'b1;
    result_last[1]     = 1'b1;

    case (sample_format)
      FMT_PCM8: begin
        result_count = 2'd1;
      end
      FMT_PCM16: begin
        if (!ph) begin
          held_low_byte_next = a_byte;
          byte_phase_next    = 1'b1;
        end else begin
          byte_phase_next  = 1'b0;
          result_sample[0] = {a_byte, held_low_byte};
          result_count     = 2'd1;
        end
      end
      FMT_ADPCM: begin
        if (hc < HEADER_BYTES) begin
          case (hc)
            HDR_PRED_LO: held_low_byte_next = a_byte;
            HDR_PRED_HI: predictor_next     = {a_byte, held_low_byte};
            HDR_STEP:    step_position_next = (hdr_idx > STEP_MAX) ? STEP_MAX : hdr_idx;
            default:     ;
          endcase
          header_count_next = hc + 3'd1;
        end else begin
          predictor_next     = nib_hi.pred;
          step_position_next = nib_hi.idx;
          result_sample[0]   = nib_lo.pred;
          result_last[0]     = 1'b0;
          result_count       = 2'd2;
        end
      end
      default: begin
        // Unused format: drop the byte and leave all state untouched.
        header_count_next = header_count;
        byte_phase_next   = byte_phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor     <= '0;
      step_position <= '0;
      header_count  <= '0;
      held_low_byte <= '0;
      byte_phase    <= 1'b0;
    end else if (process) begin
      predictor     <= predictor_next;
      step_position <= step_position_next;
      header_count  <= header_count_next;
      held_low_byte <= held_low_byte_next;
      byte_phase    <= byte_phase_next;
    end
  end

  // Input register control and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (process) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_byte  <= payload.data_byte;
      a_start <= payload.wave_start;
    end
  end

  // Result pair: load on process, otherwise advance the head on each output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= 2'd0;
    end else if (process) begin
      pair_count <= result_count;
    end else if (out_fire) begin
      pair_count <= pair_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      pair_sample[0] <= result_sample[0];
      pair_sample[1] <= result_sample[1];
      pair_last[0]   <= result_last[0];
      pair_last[1]   <= result_last[1];
    end else if (out_fire) begin
      pair_sample[0] <= pair_sample[1];
      pair_last[0]   <= pair_last[1];
    end
  end

endmodule

// ===== rtl/core/wsd_checker.sv =====
// Port-level assertions for the wave sample decoder and their bind.
module wsd_port_props (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample,
  input logic        out_last
);

  // Hold a stalled sample.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("stalled sample changed");

  // The first sample of an ADPCM pair is always followed by its partner.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second sample of a pair missing");

  // Input only stalls while results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind wave_sample_decoder wsd_port_props u_wsd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (payload.ready),
  .out_valid  (samples.valid),
  .out_ready  (samples.ready),
  .out_sample (samples.sample_value),
  .out_last   (samples.last_of_item)
);
